>>> rtl/core/mdalu_pkg.sv
`timescale 1ns / 1ps

package mdalu_pkg;

  // Opcodes
  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0a;
  localparam logic [5:0] OP_SLTIU = 6'h0b;
  localparam logic [5:0] OP_ANDI  = 6'h0c;
  localparam logic [5:0] OP_ORI   = 6'h0d;
  localparam logic [5:0] OP_LUI   = 6'h0f;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_LBU   = 6'h24;
  localparam logic [5:0] OP_LHU   = 6'h25;
  localparam logic [5:0] OP_SB    = 6'h28;
  localparam logic [5:0] OP_SH    = 6'h29;
  localparam logic [5:0] OP_SW    = 6'h2b;
  localparam logic [5:0] OP_LL    = 6'h30;
  localparam logic [5:0] OP_SC    = 6'h38;

  // R-type function codes
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2a;
  localparam logic [5:0] FN_SLTU = 6'h2b;

  localparam logic [4:0] LINK_REG = 5'd31;

  typedef enum logic [3:0] {
    ALU_ADD, ALU_AND, ALU_NOR, ALU_OR, ALU_SLT, ALU_SLL, ALU_SRL, ALU_LUI, ALU_SUB
  } alu_op_t;

  typedef enum logic [1:0] {
    RES_ALU, RES_LINK, RES_ZERO
  } res_sel_t;

  typedef enum logic [1:0] {
    TGT_NONE, TGT_REG, TGT_JUMP, TGT_BRANCH
  } tgt_sel_t;

  typedef struct packed {
    logic [31:0]        instruction;
    logic [31:0]        pc;
    logic signed [31:0] rs_data;
    logic signed [31:0] rt_data;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic [4:0]         dest_reg;
    logic               reg_write;
    logic               mem_read;
    logic               mem_write;
    logic signed [31:0] store_data;
    logic               is_branch;
    logic               branch_taken;
    logic               is_jump;
    logic [31:0]        target;
  } out_req_t;

  // Decoded controls handed from decode to execute
  typedef struct packed {
    alu_op_t    alu_op;
    logic       b_from_rt;
    logic       imm_zext;
    res_sel_t   res_sel;
    tgt_sel_t   tgt_sel;
    logic       is_beq;
    logic       is_bne;
    logic       is_load;
    logic       is_store;
    logic       is_branch;
    logic       is_jump;
    logic       reg_write;
    logic [4:0] dest_reg;
  } ctrl_t;

endpackage

>>> rtl/core/mdalu_decode.sv
`timescale 1ns / 1ps

module mdalu_decode
  import mdalu_pkg::*;
(
  input  logic [31:0] instruction,
  output ctrl_t       ctrl
);

  logic [5:0] op;
  logic [5:0] fn;
  logic [4:0] rt;
  logic [4:0] rd;
  logic       is_jr;

  assign op    = instruction[31:26];
  assign fn    = instruction[5:0];
  assign rt    = instruction[20:16];
  assign rd    = instruction[15:11];
  assign is_jr = (op == OP_RTYPE) && (fn == FN_JR);

  always_comb begin
    ctrl           = '0;
    ctrl.alu_op    = ALU_ADD;
    ctrl.res_sel   = RES_ALU;
    ctrl.tgt_sel   = TGT_NONE;
    ctrl.b_from_rt = (op == OP_RTYPE) || (op == OP_BEQ) || (op == OP_BNE);
    ctrl.imm_zext  = (op == OP_ORI);
    ctrl.is_beq    = (op == OP_BEQ);
    ctrl.is_bne    = (op == OP_BNE);
    ctrl.is_branch = (op == OP_BEQ) || (op == OP_BNE);
    ctrl.is_load   = (op == OP_LW) || (op == OP_LBU) || (op == OP_LHU) || (op == OP_LL);
    ctrl.is_store  = (op == OP_SB) || (op == OP_SH) || (op == OP_SW) || (op == OP_SC);
    ctrl.is_jump   = (op == OP_J) || (op == OP_JAL) || is_jr;
    ctrl.reg_write = !(ctrl.is_store || ctrl.is_branch || (op == OP_J) || is_jr);

    unique case (op)
      OP_RTYPE: begin
        unique case (fn)
          FN_AND:                    ctrl.alu_op = ALU_AND;
          FN_NOR:                    ctrl.alu_op = ALU_NOR;
          FN_OR:                     ctrl.alu_op = ALU_OR;
          FN_SLL:                    ctrl.alu_op = ALU_SLL;
          FN_SRL:                    ctrl.alu_op = ALU_SRL;
          FN_SLT, FN_SLTU:           ctrl.alu_op = ALU_SLT;
          FN_SUB, FN_SUBU:           ctrl.alu_op = ALU_SUB;
          default:                   ctrl.alu_op = ALU_ADD;
        endcase
      end
      OP_ANDI:                       ctrl.alu_op = ALU_AND;
      OP_ORI:                        ctrl.alu_op = ALU_OR;
      OP_LUI:                        ctrl.alu_op = ALU_LUI;
      OP_SLTI, OP_SLTIU:             ctrl.alu_op = ALU_SLT;
      default:                       ctrl.alu_op = ALU_ADD;
    endcase

    if (op == OP_JAL) begin
      ctrl.res_sel = RES_LINK;
    end else if (ctrl.is_jump) begin
      ctrl.res_sel = RES_ZERO;
    end

    if (is_jr) begin
      ctrl.tgt_sel = TGT_REG;
    end else if ((op == OP_J) || (op == OP_JAL)) begin
      ctrl.tgt_sel = TGT_JUMP;
    end else if (ctrl.is_branch) begin
      ctrl.tgt_sel = TGT_BRANCH;
    end

    if (!ctrl.reg_write) begin
      ctrl.dest_reg = '0;
    end else if (op == OP_RTYPE) begin
      ctrl.dest_reg = rd;
    end else if (op == OP_JAL) begin
      ctrl.dest_reg = LINK_REG;
    end else begin
      ctrl.dest_reg = rt;
    end
  end

endmodule

>>> rtl/core/mdalu_exec.sv
`timescale 1ns / 1ps

module mdalu_exec
  import mdalu_pkg::*;
(
  input  in_req_t  req,
  input  ctrl_t    ctrl,
  output out_req_t res
);

  logic [15:0] imm;
  logic [4:0]  shamt;
  logic [31:0] sext;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] alu_y;
  logic [31:0] link_pc;
  logic [31:0] br_target;
  logic [31:0] jmp_target;

  assign imm        = req.instruction[15:0];
  assign shamt      = req.instruction[10:6];
  assign sext       = {{16{imm[15]}}, imm};
  assign a          = req.rs_data;
  assign b          = ctrl.b_from_rt ? req.rt_data :
                      (ctrl.imm_zext ? {16'h0000, imm} : sext);
  assign link_pc    = req.pc + 32'd8;
  assign br_target  = req.pc + 32'd4 + {sext[29:0], 2'b00};
  assign jmp_target = {req.pc[31:28], req.instruction[25:0], 2'b00};

  always_comb begin
    unique case (ctrl.alu_op)
      ALU_AND: alu_y = a & b;
      ALU_NOR: alu_y = ~(a | b);
      ALU_OR:  alu_y = a | b;
      ALU_SLT: alu_y = {31'd0, ($signed(a) < $signed(b))};
      ALU_SLL: alu_y = b << shamt;
      ALU_SRL: alu_y = b >> shamt;
      ALU_LUI: alu_y = {b[15:0], 16'h0000};
      ALU_SUB: alu_y = a - b;
      default: alu_y = a + b;
    endcase
  end

  always_comb begin
    res              = '0;
    res.dest_reg     = ctrl.dest_reg;
    res.reg_write    = ctrl.reg_write;
    res.mem_read     = ctrl.is_load;
    res.mem_write    = ctrl.is_store;
    res.store_data   = ctrl.is_store ? req.rt_data : '0;
    res.is_branch    = ctrl.is_branch;
    res.is_jump      = ctrl.is_jump;
    res.branch_taken = (ctrl.is_beq && (req.rs_data == req.rt_data)) ||
                       (ctrl.is_bne && (req.rs_data != req.rt_data));

    case (ctrl.res_sel)
      RES_LINK: res.result = link_pc;
      RES_ZERO: res.result = '0;
      default:  res.result = alu_y;
    endcase

    case (ctrl.tgt_sel)
      TGT_REG:    res.target = req.rs_data;
      TGT_JUMP:   res.target = jmp_target;
      TGT_BRANCH: res.target = br_target;
      default:    res.target = '0;
    endcase
  end

endmodule

>>> rtl/core/mips_decode_and_alu_unit.sv
// Channel   Ports                            Moves
// --------  -------------------------------  ---------------------------------------
// input     in_valid / in_ready / in_data    instruction, pc, rs_data, rt_data
// result    out_valid / out_ready / out_data ALU result, controls, store data, target
//
// A taken request lands in the input register, is decoded and executed from there, and
// lands in the result register once that stage is free, which raises out_valid; one
// request is taken every cycle unless the input side stalls. rst_n (synchronous, active
// low) clears both valid flags only.
// A stalled result holds in the result register while the input register can still
// take one more request, so the input side stalls only when both stages are full.
`timescale 1ns / 1ps

module mips_decode_and_alu_unit
  import mdalu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_data
);

  // Stage one: registered request
  in_req_t  req_r;
  logic     req_valid_r;
  logic     req_valid_nxt;

  // Stage two: registered result
  out_req_t res_r;
  logic     res_valid_r;
  logic     res_valid_nxt;

  ctrl_t    ctrl;
  out_req_t res_nxt;

  logic     res_ready;
  logic     res_load;

  // The result stage frees up when empty or when its request is taken this cycle.
  assign res_ready = !res_valid_r || out_ready;
  assign res_load  = req_valid_r && res_ready;
  // Take a new request when stage one is empty or is advancing.
  assign in_ready  = !req_valid_r || res_ready;

  mdalu_decode u_decode (
    .instruction (req_r.instruction),
    .ctrl        (ctrl)
  );

  mdalu_exec u_exec (
    .req  (req_r),
    .ctrl (ctrl),
    .res  (res_nxt)
  );

  always_comb begin
    req_valid_nxt = req_valid_r;
    if (in_ready) begin
      req_valid_nxt = in_valid;
    end
    res_valid_nxt = res_valid_r;
    if (res_ready) begin
      res_valid_nxt = req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Payload registers: load on advance, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r <= in_data;
    end
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = res_valid_r;
  assign out_data  = res_r;

endmodule

>>> rtl/core/mdalu_check.sv
`timescale 1ns / 1ps

module mdalu_check
  import mdalu_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input out_req_t out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // An empty result stage never blocks the input side.
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result stage");

  // A request accepted while the result stage is empty is followed by a valid result.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("accepted request lost");

  a_dest_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.reg_write |-> out_data.dest_reg == 5'd0)
    else $error("destination set without register write");

  a_store_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.mem_write && out_data.reg_write) &&
                  (out_data.branch_taken ? out_data.is_branch : 1'b1))
    else $error("inconsistent control outputs");

endmodule

bind mips_decode_and_alu_unit mdalu_check u_mdalu_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> dv/mips_decode_and_alu_unit_test.sv
`timescale 1ns / 1ps

module mips_decode_and_alu_unit_test;
  import mdalu_pkg::*;

  // Opcode and funct values that the decoder does not know; both fall back to add.
  localparam logic [5:0] OP_UNUSED = 6'h3f;
  localparam logic [5:0] FN_UNUSED = 6'h3f;

  localparam int RANDOM_REQUESTS = 1600;
  localparam int CYCLE_LIMIT     = 100000;
  localparam int IDLE_PERCENT    = 14;
  localparam int DRAIN_CYCLES    = 10;

  // One directed request: either checked against the predictor or against a
  // hand-typed answer that can be read straight off the instruction.
  typedef struct {
    in_req_t  req;
    bit       fixed;
    out_req_t want;
  } program_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_req_t out_data;

  out_req_t     pending_results[$];
  program_row_t program_rows[$];
  int           error_count = 0;
  int           cycle_count = 0;
  bit           calm = 1'b0;   // high while neither side may idle

  mips_decode_and_alu_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Instruction encoders
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] r_word(input logic [5:0] fn, input logic [4:0] rs,
                                         input logic [4:0] rt, input logic [4:0] rd,
                                         input logic [4:0] sh);
    return {OP_RTYPE, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] i_word(input logic [5:0] op, input logic [4:0] rs,
                                         input logic [4:0] rt, input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic in_req_t make_req(input logic [31:0] ins, input logic [31:0] pc,
                                       input logic [31:0] rs_v, input logic [31:0] rt_v);
    in_req_t r;
    r.instruction = ins;
    r.pc          = pc;
    r.rs_data     = rs_v;
    r.rt_data     = rt_v;
    return r;
  endfunction

  function automatic out_req_t fixed_result(input logic [31:0] res, input logic [4:0] dest,
                                            input logic wr, input logic rd, input logic wm,
                                            input logic [31:0] sd, input logic br,
                                            input logic tk, input logic jmp,
                                            input logic [31:0] tgt);
    out_req_t o;
    o.result       = res;
    o.dest_reg     = dest;
    o.reg_write    = wr;
    o.mem_read     = rd;
    o.mem_write    = wm;
    o.store_data   = sd;
    o.is_branch    = br;
    o.branch_taken = tk;
    o.is_jump      = jmp;
    o.target       = tgt;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: decode the word, pick the second operand, run the ALU and
  // work out the branch or jump target. The block keeps no state.
  // ---------------------------------------------------------------------------
  function automatic out_req_t decode_execute(input in_req_t r);
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [31:0] sext;
    logic [31:0] imm_opnd;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] alu_v;
    logic        jr;
    logic        store;
    logic        load;
    logic        br;
    logic        jmp;
    logic        wr;
    alu_op_t     f;
    out_req_t    o;

    op = r.instruction[31:26];
    rt = r.instruction[20:16];
    rd = r.instruction[15:11];
    sh = r.instruction[10:6];
    fn = r.instruction[5:0];
    sext = {{16{r.instruction[15]}}, r.instruction[15:0]};
    // ori is the one immediate that is zero-extended
    imm_opnd = (op == OP_ORI) ? {16'h0000, r.instruction[15:0]} : sext;

    jr    = (op == OP_RTYPE) && (fn == FN_JR);
    store = (op == OP_SB) || (op == OP_SH) || (op == OP_SW) || (op == OP_SC);
    load  = (op == OP_LW) || (op == OP_LBU) || (op == OP_LHU) || (op == OP_LL);
    br    = (op == OP_BEQ) || (op == OP_BNE);
    jmp   = (op == OP_J) || (op == OP_JAL) || jr;
    wr    = !(store || br || (op == OP_J) || jr);

    if (op == OP_RTYPE) begin
      case (fn)
        FN_AND:          f = ALU_AND;
        FN_NOR:          f = ALU_NOR;
        FN_OR:           f = ALU_OR;
        FN_SLT, FN_SLTU: f = ALU_SLT;
        FN_SLL:          f = ALU_SLL;
        FN_SRL:          f = ALU_SRL;
        FN_SUB, FN_SUBU: f = ALU_SUB;
        default:         f = ALU_ADD;
      endcase
    end else begin
      case (op)
        OP_ANDI:           f = ALU_AND;
        OP_ORI:            f = ALU_OR;
        OP_LUI:            f = ALU_LUI;
        OP_SLTI, OP_SLTIU: f = ALU_SLT;
        default:           f = ALU_ADD;
      endcase
    end

    a = r.rs_data;
    b = ((op == OP_RTYPE) || br) ? r.rt_data : imm_opnd;
    case (f)
      ALU_AND: alu_v = a & b;
      ALU_NOR: alu_v = ~(a | b);
      ALU_OR:  alu_v = a | b;
      // sltu compares signed as well
      ALU_SLT: alu_v = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      ALU_SLL: alu_v = b << sh;
      ALU_SRL: alu_v = b >> sh;
      ALU_LUI: alu_v = b << 16;
      ALU_SUB: alu_v = a - b;
      default: alu_v = a + b;
    endcase

    o = '0;
    o.reg_write = wr;
    o.mem_read  = load;
    o.mem_write = store;
    o.is_branch = br;
    o.is_jump   = jmp;
    if (wr) begin
      if (op == OP_RTYPE)   o.dest_reg = rd;
      else if (op == OP_JAL) o.dest_reg = LINK_REG;
      else                   o.dest_reg = rt;
    end
    if (op == OP_JAL)  o.result = r.pc + 32'd8;
    else if (!jmp)     o.result = alu_v;
    if (store)         o.store_data = r.rt_data;
    if (op == OP_BEQ)  o.branch_taken = (r.rs_data == r.rt_data);
    if (op == OP_BNE)  o.branch_taken = (r.rs_data != r.rt_data);
    if (jr)
      o.target = r.rs_data;
    else if ((op == OP_J) || (op == OP_JAL))
      o.target = {r.pc[31:28], r.instruction[25:0], 2'b00};
    else if (br)
      o.target = r.pc + 32'd4 + {sext[29:0], 2'b00};
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Random pickers
  // ---------------------------------------------------------------------------
  function automatic bit idle_now();
    return !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
  endfunction

  // Mostly full-range words, with the edges of the range mixed in.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h7fff_ffff;
      3:       return 32'h8000_0000;
      4:       return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [5:0] pick_opcode();
    case ($urandom_range(0, 21))
      0, 1:    return OP_RTYPE;
      2:       return OP_J;
      3:       return OP_JAL;
      4:       return OP_BEQ;
      5:       return OP_BNE;
      6:       return OP_ADDI;
      7:       return OP_ADDIU;
      8:       return OP_SLTI;
      9:       return OP_SLTIU;
      10:      return OP_ANDI;
      11:      return OP_ORI;
      12:      return OP_LUI;
      13:      return OP_LW;
      14:      return OP_LBU;
      15:      return OP_LHU;
      16:      return OP_SB;
      17:      return OP_SH;
      18:      return OP_SW;
      19:      return OP_LL;
      20:      return OP_SC;
      default: return 6'($urandom);
    endcase
  endfunction

  function automatic logic [5:0] pick_funct();
    case ($urandom_range(0, 12))
      0:       return FN_SLL;
      1:       return FN_SRL;
      2:       return FN_JR;
      3:       return FN_ADD;
      4:       return FN_ADDU;
      5:       return FN_SUB;
      6:       return FN_SUBU;
      7:       return FN_AND;
      8:       return FN_OR;
      9:       return FN_NOR;
      10:      return FN_SLT;
      11:      return FN_SLTU;
      default: return 6'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver. Entered and left at a rising edge; on return the request
  // has just been taken. Log the expected result at the moment of acceptance.
  // ---------------------------------------------------------------------------
  task automatic send_request(input in_req_t r, input bit fixed, input out_req_t want);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(fixed ? want : decode_execute(r));
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
      error_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall at random, and compare every taken result with the
  // oldest outstanding expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_req_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing outstanding: result 0x%08h", out_data.result);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("result",       want.result,       out_data.result);
        check_field("dest_reg",     32'(want.dest_reg),     32'(out_data.dest_reg));
        check_field("reg_write",    32'(want.reg_write),    32'(out_data.reg_write));
        check_field("mem_read",     32'(want.mem_read),     32'(out_data.mem_read));
        check_field("mem_write",    32'(want.mem_write),    32'(out_data.mem_write));
        check_field("store_data",   want.store_data,   out_data.store_data);
        check_field("is_branch",    32'(want.is_branch),    32'(out_data.is_branch));
        check_field("branch_taken", 32'(want.branch_taken), 32'(out_data.branch_taken));
        check_field("is_jump",      32'(want.is_jump),      32'(out_data.is_jump));
        check_field("target",       want.target,       out_data.target);
      end
    end
    out_ready <= !idle_now();
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("mips_decode_and_alu_unit_test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    in_req_t     r;
    logic [5:0]  op;
    logic [31:0] ins;

    // Directed rows: field extremes, every ALU operation, every load/store
    // class, both branches, the three jumps, and the unknown-code fallbacks.
    program_rows.push_back('{make_req(r_word(FN_ADD, 5'd1, 5'd2, 5'd3, 5'd0), 32'h0,
        32'h7fff_ffff, 32'h1), 1'b1,
        fixed_result(32'h8000_0000, 5'd3, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0,
                     32'h0)});
    program_rows.push_back('{make_req(r_word(FN_SUB, 5'd4, 5'd5, 5'd6, 5'd0), 32'h4,
        32'h8000_0000, 32'h1), 1'b0, '0});
    program_rows.push_back('{make_req(r_word(FN_AND, 5'd7, 5'd8, 5'd9, 5'd0), 32'h8,
        32'hffff_ffff, 32'h5a5a_a5a5), 1'b0, '0});
    program_rows.push_back('{make_req(r_word(FN_OR, 5'd0, 5'd31, 5'd31, 5'd31), 32'hc,
        32'h0f0f_0f0f, 32'hf000_0000), 1'b0, '0});
    program_rows.push_back('{make_req(r_word(FN_NOR, 5'd1, 5'd1, 5'd0, 5'd0), 32'h10,
        32'h0, 32'h0), 1'b0, '0});
    program_rows.push_back('{make_req(r_word(FN_SLT, 5'd2, 5'd3, 5'd4, 5'd0), 32'h14,
        32'hffff_ffff, 32'h1), 1'b0, '0});
    // sltu ordering as signed: all-ones counts as minus one
    program_rows.push_back('{make_req(r_word(FN_SLTU, 5'd2, 5'd3, 5'd4, 5'd0), 32'h18,
        32'hffff_ffff, 32'h1), 1'b0, '0});
    program_rows.push_back('{make_req(r_word(FN_SLL, 5'd0, 5'd3, 5'd5, 5'd31), 32'h1c,
        32'h0, 32'h1), 1'b0, '0});
    // srl must shift in zeros even from a negative value
    program_rows.push_back('{make_req(r_word(FN_SRL, 5'd0, 5'd3, 5'd5, 5'd31), 32'h20,
        32'h0, 32'h8000_0000), 1'b0, '0});
    program_rows.push_back('{make_req(r_word(FN_JR, 5'd31, 5'd0, 5'd0, 5'd0), 32'h100,
        32'hdead_beef, 32'h1234_5678), 1'b1,
        fixed_result(32'h0, 5'd0, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b1,
                     32'hdead_beef)});
    program_rows.push_back('{make_req(r_word(FN_UNUSED, 5'd1, 5'd2, 5'd10, 5'd7), 32'h24,
        32'hffff_fff0, 32'h20), 1'b0, '0});
    program_rows.push_back('{make_req(i_word(OP_ADDI, 5'd1, 5'd2, 16'h8000), 32'h28,
        32'h8000_0000, 32'h0), 1'b0, '0});
    program_rows.push_back('{make_req(i_word(OP_SLTI, 5'd1, 5'd2, 16'hffff), 32'h2c,
        32'h8000_0000, 32'h0), 1'b0, '0});
    program_rows.push_back('{make_req(i_word(OP_ANDI, 5'd1, 5'd2, 16'hffff), 32'h30,
        32'hffff_ffff, 32'h0), 1'b0, '0});
    // ori zero-extends, so the top half must stay clear
    program_rows.push_back('{make_req(i_word(OP_ORI, 5'd1, 5'd2, 16'h8000), 32'h34,
        32'h0, 32'h0), 1'b0, '0});
    program_rows.push_back('{make_req(i_word(OP_LUI, 5'd0, 5'd31, 16'hffff), 32'h38,
        32'h1234_5678, 32'h0), 1'b0, '0});
    program_rows.push_back('{make_req(i_word(OP_LW, 5'd29, 5'd8, 16'hfffc), 32'h3c,
        32'h0000_0002, 32'h0), 1'b0, '0});
    program_rows.push_back('{make_req(i_word(OP_SW, 5'd1, 5'd5, 16'hffff), 32'h0,
        32'h0, 32'h8000_0000), 1'b1,
        fixed_result(32'hffff_ffff, 5'd0, 1'b0, 1'b0, 1'b1, 32'h8000_0000, 1'b0, 1'b0,
                     1'b0, 32'h0)});
    program_rows.push_back('{make_req(i_word(OP_LBU, 5'd3, 5'd9, 16'h7fff), 32'h40,
        32'h7fff_ffff, 32'h0), 1'b0, '0});
    program_rows.push_back('{make_req(i_word(OP_SC, 5'd3, 5'd9, 16'h0004), 32'h44,
        32'h1000, 32'h7fff_ffff), 1'b0, '0});
    // beq taken with the most negative offset, wrapping below zero
    program_rows.push_back('{make_req(i_word(OP_BEQ, 5'd1, 5'd2, 16'h8000), 32'h0,
        32'hffff_ffff, 32'hffff_ffff), 1'b0, '0});
    program_rows.push_back('{make_req(i_word(OP_BNE, 5'd1, 5'd2, 16'h7fff), 32'hffff_fff8,
        32'h55, 32'h55), 1'b0, '0});
    program_rows.push_back('{make_req({OP_J, 26'h3ff_ffff}, 32'hffff_fffc,
        32'h1, 32'h2), 1'b1,
        fixed_result(32'h0, 5'd0, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b1,
                     32'hffff_fffc)});
    // jal link wraps past the top of the address space
    program_rows.push_back('{make_req({OP_JAL, 26'h0}, 32'hffff_fffc,
        32'h1, 32'h2), 1'b1,
        fixed_result(32'h0000_0004, LINK_REG, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b1,
                     32'hf000_0000)});
    program_rows.push_back('{make_req(i_word(OP_UNUSED, 5'd0, 5'd7, 16'h8000), 32'h48,
        32'h0, 32'hffff_ffff), 1'b1,
        fixed_result(32'hffff_8000, 5'd7, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0,
                     32'h0)});

    // Hold reset, then release it and start driving on the same edge.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (program_rows[i])
      send_request(program_rows[i].req, program_rows[i].fixed, program_rows[i].want);

    // Random part: mostly well-formed words with random fields, the rest raw noise.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      calm = (n >= 700) && (n < 1000);
      ins = $urandom;
      if ($urandom_range(0, 99) < 85) begin
        op = pick_opcode();
        ins[31:26] = op;
        if (op == OP_RTYPE) ins[5:0] = pick_funct();
        if ($urandom_range(0, 3) == 0) ins[15:0] = 16'(pick_word());
      end
      r = make_req(ins, pick_word(), pick_word(), pick_word());
      // Force equal operands often enough that both branch outcomes show up.
      if ($urandom_range(0, 2) == 0) r.rt_data = r.rs_data;
      send_request(r, 1'b0, '0);
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    // Drain: wait out every outstanding result, then idle before the verdict.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("mips_decode_and_alu_unit_test passed");
    else
      $display("mips_decode_and_alu_unit_test failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/mdalu_pkg.sv
rtl/core/mdalu_decode.sv
rtl/core/mdalu_exec.sv
rtl/core/mips_decode_and_alu_unit.sv
rtl/core/mdalu_check.sv
dv/mips_decode_and_alu_unit_test.sv
